### design/csrspmv_pkg.sv
// ----------------------------------------------------------------------------
// csrspmv_pkg
// Shared types and codes for the CSR sparse matrix-vector multiply block.
// ----------------------------------------------------------------------------
package csrspmv_pkg;

    // request kinds carried on s_tuser
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_NONZERO = 2'd1;
    localparam logic [1:0] REQ_EMPTY   = 2'd2;

    localparam int COL_W     = 12;
    localparam int VAL_W     = 32;
    localparam int ROW_W     = 32;
    localparam int SUM_W     = 64;
    localparam int IN_DATA_W = 48;                 // 12 + 32, padded to bytes
    localparam int OUT_DATA_W = ROW_W + SUM_W;     // 96

    // result buffer depth; covers the two pipeline stages plus slack
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    // item leaving the memory read stage
    typedef struct packed {
        logic               valid;
        logic [1:0]         kind;
        logic               last;
        logic               in_range;
        logic [VAL_W-1:0]   value;
    } rd_stage_t;

    // result handed to the output buffer
    typedef struct packed {
        logic               push;
        logic [ROW_W-1:0]   row_index;
        logic [SUM_W-1:0]   row_sum;
    } result_t;

endpackage

### design/csrspmv_vec_mem.sv
// ----------------------------------------------------------------------------
// csrspmv_vec_mem
// Dense vector store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module csrspmv_vec_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [csrspmv_pkg::VAL_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [csrspmv_pkg::VAL_W-1:0] rd_data
);
    import csrspmv_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/csrspmv_mac.sv
// ----------------------------------------------------------------------------
// csrspmv_mac
// Registered multiply, then saturating row accumulate and row numbering.
// ----------------------------------------------------------------------------
module csrspmv_mac (
    input  logic                        clk,
    input  logic                        rst_n,
    input  csrspmv_pkg::rd_stage_t      stage_in,
    input  logic [csrspmv_pkg::VAL_W-1:0] elem,
    output csrspmv_pkg::result_t        result
);
    import csrspmv_pkg::*;

    logic                   v2_reg;
    logic                   v2_next;
    logic [1:0]             kind2_reg;
    logic                   last2_reg;
    logic signed [SUM_W-1:0] prod_reg;
    logic signed [SUM_W-1:0] prod_next;
    logic signed [VAL_W-1:0] a_s;
    logic signed [VAL_W-1:0] b_s;

    logic [SUM_W-1:0]       acc_reg;
    logic [SUM_W-1:0]       acc_next;
    logic [ROW_W-1:0]       row_cnt_reg;
    logic [ROW_W-1:0]       row_cnt_next;
    logic [SUM_W-1:0]       sum_raw;
    logic [SUM_W-1:0]       sum_sat;

    // element reads as zero when the column lies past the vector
    assign a_s       = stage_in.in_range ? $signed(elem) : '0;
    assign b_s       = $signed(stage_in.value);
    assign prod_next = a_s * b_s;
    assign v2_next   = stage_in.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind2_reg <= stage_in.kind;
        last2_reg <= stage_in.last;
        prod_reg  <= prod_next;
    end

    // saturating add: overflow when both signs agree and the result flips
    assign sum_raw = acc_reg + prod_reg;

    always_comb
    begin
        sum_sat = sum_raw;
        if ((acc_reg[SUM_W-1] == prod_reg[SUM_W-1]) &&
            (sum_raw[SUM_W-1] != acc_reg[SUM_W-1]))
        begin
            sum_sat = acc_reg[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        acc_next         = acc_reg;
        row_cnt_next     = row_cnt_reg;
        result.push      = 1'b0;
        result.row_index = row_cnt_reg;
        result.row_sum   = '0;
        if (v2_reg)
        begin
            priority if (kind2_reg == REQ_NONZERO)
            begin
                if (last2_reg)
                begin
                    result.push    = 1'b1;
                    result.row_sum = sum_sat;
                    acc_next       = '0;
                    row_cnt_next   = row_cnt_reg + 1'b1;
                end
                else
                begin
                    acc_next = sum_sat;
                end
            end
            else if (kind2_reg == REQ_EMPTY)
            begin
                // partial sum stays put and carries on
                result.push  = 1'b1;
                row_cnt_next = row_cnt_reg + 1'b1;
            end
            else
            begin
                acc_next = acc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            acc_reg     <= acc_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

endmodule

### design/csrspmv_out_fifo.sv
// ----------------------------------------------------------------------------
// csrspmv_out_fifo
// Small result buffer between the accumulator and the master port.
// ----------------------------------------------------------------------------
module csrspmv_out_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  csrspmv_pkg::result_t              result,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [csrspmv_pkg::OUT_DATA_W-1:0] out_data,
    output logic [csrspmv_pkg::OUT_CNT_W-1:0]  count
);
    import csrspmv_pkg::*;

    logic [OUT_DATA_W-1:0] buf_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  wr_ptr_reg;
    logic [OUT_PTR_W-1:0]  wr_ptr_next;
    logic [OUT_PTR_W-1:0]  rd_ptr_reg;
    logic [OUT_PTR_W-1:0]  rd_ptr_next;
    logic [OUT_CNT_W-1:0]  cnt_reg;
    logic [OUT_CNT_W-1:0]  cnt_next;
    logic                  pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = buf_reg[rd_ptr_reg];
    assign count     = cnt_reg;

    always_comb
    begin
        wr_ptr_next = result.push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + OUT_CNT_W'(result.push) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (result.push)
        begin
            buf_reg[wr_ptr_reg] <= {result.row_sum, result.row_index};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### design/csr_sparse_matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply
// CSR sparse matrix times dense vector, Q16.16 inputs, saturated Q32.32 sums.
// ----------------------------------------------------------------------------
//  port group | role   | tdata (low bit up)                      | tuser / tlast
//  s_*        | input  | column_index[11:0], entry_value[43:12]  | req_type / end_of_row
//  m_*        | output | row_index[31:0], row_sum[95:32]         | none / none
//
//  One item per cycle sustained while s_tready is high. An input transfer
//  passes through vector memory read, multiply register and accumulate into
//  the result buffer. The accumulator feedback is a single 64-bit add.
//  Reset clears the running sum, row counter and buffer state; the vector
//  memory is not cleared and holds garbage until loaded.
//  s_tready drops only when the four-entry result buffer, counting items
//  still in the pipeline, could overflow; the pipeline itself never stalls.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply #(
    parameter int VECTOR_LEN = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // column_index[11:0], entry_value[43:12], zero pad[47:44]
    input  logic [csrspmv_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [1:0]                         s_tuser,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // row_index[31:0], row_sum[95:32]
    output logic [csrspmv_pkg::OUT_DATA_W-1:0] m_tdata
);
    import csrspmv_pkg::*;

    localparam int AW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
    localparam logic [16:0] LEN = 17'(VECTOR_LEN);

    logic              accept;
    logic [COL_W-1:0]  col;
    logic [VAL_W-1:0]  value;
    logic              in_range;
    logic [AW-1:0]     addr;
    logic [VAL_W-1:0]  elem;
    logic [OUT_CNT_W-1:0] buf_count;
    logic [OUT_CNT_W-1:0] in_flight;
    // multiply stage occupancy, tracked locally to size the ready window
    logic              s2_valid_reg;

    rd_stage_t         s1_reg;
    rd_stage_t         s1_next;
    result_t           result;

    assign col      = s_tdata[COL_W-1:0];
    assign value    = s_tdata[COL_W +: VAL_W];
    assign in_range = 17'(col) < LEN;
    assign addr     = AW'(col);
    assign accept   = s_tvalid && s_tready;

    // buffered plus in-flight results must leave room for one more
    assign in_flight = buf_count + OUT_CNT_W'(s1_reg.valid) + OUT_CNT_W'(s2_valid_reg);
    assign s_tready  = (in_flight < OUT_CNT_W'(OUT_DEPTH));

    // loads finish at the memory write; only nonzero and empty-row items go on
    always_comb
    begin
        s1_next.valid    = accept && ((s_tuser == REQ_NONZERO) || (s_tuser == REQ_EMPTY));
        s1_next.kind     = s_tuser;
        s1_next.last     = s_tlast;
        s1_next.in_range = in_range;
        s1_next.value    = value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    // a load written here is visible to a nonzero read accepted in the next cycle
    csrspmv_vec_mem #(
        .DEPTH (VECTOR_LEN),
        .AW    (AW)
    ) u_vec_mem (
        .clk     (clk),
        .wr_en   (accept && (s_tuser == REQ_LOAD) && in_range),
        .wr_addr (addr),
        .wr_data (value),
        .rd_en   (accept),
        .rd_addr (addr),
        .rd_data (elem)
    );

    csrspmv_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage_in (s1_reg),
        .elem     (elem),
        .result   (result)
    );

    csrspmv_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .count     (buf_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_reg.valid;
        end
    end

endmodule

### design/csrspmv_checker.sv
// ----------------------------------------------------------------------------
// csrspmv_checker
// Port-level checks for the CSR sparse matrix-vector multiply block.
// ----------------------------------------------------------------------------
module csrspmv_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [1:0]                         s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [csrspmv_pkg::OUT_DATA_W-1:0] m_tdata
);
    import csrspmv_pkg::*;

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // a result appearing on an empty output comes from a nonzero or empty-row
    // transfer traced back through the read, multiply and buffer registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(s_tvalid && s_tready, 3) &&
                             ($past(s_tuser, 3) == REQ_NONZERO ||
                              $past(s_tuser, 3) == REQ_EMPTY)))
        else $error("result without matching input transfer");

    // backpressure only when results are already waiting
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind csr_sparse_matrix_vector_multiply csrspmv_checker u_csrspmv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CSR sparse matrix-vector multiply block.
// The bench keeps its own copy of the dense vector, the running row sum and
// the row counter. From these it predicts every row result. A checker
// compares each output transfer with the oldest prediction. Stimulus is a
// directed opening, a backpressure phase and a long random stream of
// well-formed rows mixed with loads, empty rows, broken rows and unused codes.
// ----------------------------------------------------------------------------
module testbench;
    import csrspmv_pkg::*;

    localparam logic [1:0]  REQ_UNUSED     = 2'd3;       // ignored by the block
    localparam logic [63:0] SUM_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SUM_MIN        = 64'h8000_0000_0000_0000;
    localparam logic [31:0] Q_ONE          = 32'h0001_0000;
    localparam logic [31:0] Q_MOST_NEG     = 32'h8000_0000;
    localparam logic [31:0] Q_MOST_POS     = 32'h7FFF_FFFF;
    localparam int          RANDOM_ITEMS   = 1000;
    localparam int          RX_HOLD_CYCLES = 200;
    localparam int          SETTLE_CYCLES  = 8;          // pipeline is 3 deep
    localparam int          CYCLE_LIMIT    = 300000;
    localparam int          REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [SUM_W-1:0] row_sum;
    } row_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;     // column_index[11:0], entry_value[43:12], pad[47:44]
    logic [1:0]            s_tuser;     // req_type[1:0]
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;     // row_index[31:0], row_sum[95:32]

    // bench copy of the block state
    logic [VAL_W-1:0]  vector_copy [0:4095];
    bit                vector_loaded [0:4095];
    int                loaded_columns [$];
    logic [SUM_W-1:0]  partial_sum;
    logic [ROW_W-1:0]  next_row;
    row_result_t       pending_rows [$];

    int  fail_count;
    int  cycle_count;
    bit  tx_steady;        // sender offers back to back
    bit  rx_steady;        // receiver always ready
    bit  hold_request;     // receiver stalls for a long stretch, then clears this

    csr_sparse_matrix_vector_multiply dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Update the bench state with one accepted transfer and queue the row it
    // finishes, if any.
    function automatic void predict_transfer(input logic [1:0] kind,
                                             input logic [COL_W-1:0] col,
                                             input logic [VAL_W-1:0] val,
                                             input logic last);
        longint           product;
        logic [SUM_W-1:0] total;
        row_result_t      row;
        case (kind)
            REQ_LOAD:
            begin
                vector_copy[col] = val;
                if (!vector_loaded[col])
                begin
                    vector_loaded[col] = 1'b1;
                    loaded_columns.push_back(int'(col));
                end
            end
            REQ_NONZERO:
            begin
                // exact Q32.32 product, then a saturating add
                product = longint'($signed(val)) * longint'($signed(vector_copy[col]));
                total = partial_sum + product;
                if (partial_sum[63] == product[63] && total[63] != partial_sum[63])
                    total = partial_sum[63] ? SUM_MIN : SUM_MAX;
                partial_sum = total;
                if (last)
                begin
                    row.row_index = next_row;
                    row.row_sum   = partial_sum;
                    pending_rows.push_back(row);
                    partial_sum = '0;
                    next_row++;
                end
            end
            REQ_EMPTY:
            begin
                // partial sum of an open row is left alone
                row.row_index = next_row;
                row.row_sum   = '0;
                pending_rows.push_back(row);
                next_row++;
            end
            default: ;
        endcase
    endfunction

    // Result checker: one comparison per output transfer.
    always @(posedge clk)
    begin
        row_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_rows.size() == 0)
                report_failure($sformatf("unexpected result row %0d sum %h",
                                         m_tdata[31:0], m_tdata[95:32]));
            else
            begin
                want = pending_rows.pop_front();
                if (m_tdata[31:0] !== want.row_index)
                    report_failure($sformatf("row_index expected %0d got %0d",
                                             want.row_index, m_tdata[31:0]));
                if (m_tdata[95:32] !== want.row_sum)
                    report_failure($sformatf("row %0d row_sum expected %h got %h",
                                             want.row_index, want.row_sum, m_tdata[95:32]));
            end
        end
    end

    // Receiver: random stalls, a steady stretch and one long hold-off.
    initial
    begin
        int hold_count;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                for (hold_count = 1; hold_count < RX_HOLD_CYCLES; hold_count++)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            else
                m_tready <= rx_steady || ($urandom_range(0, 99) >= 15);
        end
    end

    // Offer one item and wait for its transfer. Called and returns just after
    // a falling edge.
    task automatic send_item(input logic [1:0] kind, input logic [COL_W-1:0] col,
                             input logic [VAL_W-1:0] val, input logic last);
        while (!tx_steady && $urandom_range(0, 99) < 15)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, val, col};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_transfer(kind, col, val, last);
        @(negedge clk);
    endtask

    // Sender stops and waits until every predicted row has come out.
    task automatic wait_for_rows();
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [VAL_W-1:0] random_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            6, 7:    v = $urandom_range(0, 32'h0003_FFFF);
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       v = Q_MOST_NEG;
                    1:       v = Q_MOST_POS;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            9:       v = Q_ONE;
            default: v = $urandom;
        endcase
        // small values also come out negative
        if ($urandom_range(0, 1) && v != Q_MOST_NEG)
            v = -v;
        return v;
    endfunction

    function automatic logic [COL_W-1:0] loaded_column();
        return COL_W'(loaded_columns[$urandom_range(0, loaded_columns.size() - 1)]);
    endfunction

    // Extremes of the vector element, both ends of the column range, a flag
    // on a load and an unused request code.
    task automatic test_vector_loads();
        send_item(REQ_LOAD, 12'd0,     Q_MOST_NEG,   1'b0);
        send_item(REQ_LOAD, 12'd4095,  Q_MOST_POS,   1'b0);
        send_item(REQ_LOAD, 12'd1,     Q_ONE,        1'b0);
        send_item(REQ_LOAD, 12'd2,     32'hFFFF_FFFF, 1'b0);
        send_item(REQ_LOAD, 12'hAAA,   32'h5555_5555, 1'b0);
        send_item(REQ_LOAD, 12'h555,   32'hAAAA_AAAA, 1'b1);
        send_item(REQ_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 1'b1);
    endtask

    // Plain rows, largest product, empty rows with and without the flag.
    task automatic test_row_sums();
        send_item(REQ_NONZERO, 12'd1,    Q_ONE,        1'b1);
        send_item(REQ_NONZERO, 12'd0,    Q_MOST_NEG,   1'b1);
        send_item(REQ_EMPTY,   12'd0,    32'h0,        1'b0);
        send_item(REQ_EMPTY,   12'hFFF,  32'hFFFF_FFFF, 1'b1);
        send_item(REQ_NONZERO, 12'd2,    Q_MOST_POS,   1'b0);
        send_item(REQ_NONZERO, 12'hAAA,  32'h0,        1'b0);
        send_item(REQ_NONZERO, 12'h555,  32'hFFFF_FFFF, 1'b1);
    endtask

    // Both saturation limits; each product is close to 2^62 in magnitude.
    task automatic test_saturation();
        repeat (2)
            send_item(REQ_NONZERO, 12'd0, Q_MOST_NEG, 1'b0);
        send_item(REQ_NONZERO, 12'd0, Q_MOST_NEG, 1'b1);
        repeat (2)
            send_item(REQ_NONZERO, 12'd4095, Q_MOST_NEG, 1'b0);
        send_item(REQ_NONZERO, 12'd4095, Q_MOST_NEG, 1'b1);
    endtask

    // An empty row in the middle of a row: the open sum carries over.
    task automatic test_empty_inside_row();
        send_item(REQ_NONZERO, 12'd1, 32'h0002_0000, 1'b0);
        send_item(REQ_EMPTY,   12'd7, 32'h1234_5678, 1'b0);
        send_item(REQ_NONZERO, 12'd1, 32'hFFFF_0000, 1'b1);
    endtask

    // Receiver holds off while the sender keeps offering finished rows, so
    // the result buffer fills and the input stalls. Then the sender drains.
    task automatic test_backpressure();
        tx_steady    = 1'b1;
        hold_request = 1'b1;
        repeat (40)
            send_item(REQ_NONZERO, loaded_column(), random_value(), 1'b1);
        tx_steady = 1'b0;
        wait_for_rows();
    endtask

    // Mostly well-formed rows with random content; loads, empty rows, rows
    // cut short and unused codes in between.
    task automatic test_random_stream();
        int sent;
        int pick;
        int row_len;
        int k;
        bit cut_short;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // one stretch with no idling on either side
            tx_steady = (sent >= 300 && sent < 450);
            rx_steady = tx_steady;
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                send_item(REQ_LOAD, COL_W'($urandom), random_value(),
                          1'($urandom_range(0, 1)));
                sent++;
            end
            else if (pick < 17)
            begin
                send_item(REQ_EMPTY, COL_W'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
                sent++;
            end
            else if (pick < 20)
                send_item(REQ_UNUSED, COL_W'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
            else
            begin
                row_len   = $urandom_range(1, 6);
                cut_short = ($urandom_range(0, 9) == 0);
                for (k = 0; k < row_len; k++)
                    send_item(REQ_NONZERO, loaded_column(), random_value(),
                              (k == row_len - 1) && !cut_short);
                sent += row_len;
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = REQ_LOAD;
        s_tlast      = 1'b0;
        partial_sum  = '0;
        next_row     = '0;
        fail_count   = 0;
        cycle_count  = 0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_request = 1'b0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_vector_loads();
        test_row_sums();
        test_saturation();
        test_empty_inside_row();
        test_backpressure();
        test_random_stream();

        wait_for_rows();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

### filelist.f
design/csrspmv_pkg.sv
design/csrspmv_vec_mem.sv
design/csrspmv_mac.sv
design/csrspmv_out_fifo.sv
design/csr_sparse_matrix_vector_multiply.sv
design/csrspmv_checker.sv
tb/testbench.sv
